>>> hw/rtl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_ALWAYS(lbl, clk, rst, !(expr))
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> hw/rtl/kcht_pkg.sv
package kcht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 64;
  localparam int FIELD_W     = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_READ,
    ST_WRITE,
    ST_XREAD,
    ST_XSEND
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_match;
    logic read_hit;
    logic write_hit;
    logic insert;
    logic set_ovf;
    logic x_start;
    logic x_read;
    logic x_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic x_last;
  } ctrl_status_t;

endpackage

>>> hw/rtl/kcht_if.sv
interface kcht_in_if;
  logic                                valid;
  logic                                ready;
  kcht_pkg::cmd_t                      cmd;
  logic [kcht_pkg::FIELD_W-1:0]        key;
  logic signed [kcht_pkg::FIELD_W-1:0] count;
  logic                                is_null;

  modport source (output valid, output cmd, output key, output count, output is_null,
                  input ready);
  modport sink (input valid, input cmd, input key, input count, input is_null,
                output ready);
endinterface

interface kcht_out_if;
  logic                                valid;
  logic                                ready;
  logic [kcht_pkg::FIELD_W-1:0]        result_key;
  logic signed [kcht_pkg::FIELD_W-1:0] result_count;
  logic                                last;
  logic                                empty_map;
  logic                                overflow;

  modport source (output valid, output result_key, output result_count, output last,
                  output empty_map, output overflow, input ready);
  modport sink (input valid, input result_key, input result_count, input last,
                input empty_map, input overflow, output ready);
endinterface

>>> hw/rtl/keyed_count_histogram_table_top.sv
// Add: a null key is accepted and dropped; a new key passes accept, parallel key
// match and count memory read (insert); a known key also takes a count memory write.
// Extract of n entries: an accept step, then per result a memory read and a result
// transfer that waits for out_ready; one empty result when the table is empty.
// Reset is synchronous: the fill count and the overflow flag clear; the key and
// count stores keep their contents and need no clearing pass.
`include "assert_macros.svh"

module keyed_count_histogram_table_top (
  input logic clk,
  input logic rst,
  kcht_in_if.sink   in_ch,
  kcht_out_if.source out_ch
);
  import kcht_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  kcht_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_is_null (in_ch.is_null),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  kcht_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_key       (in_ch.key),
    .in_count     (in_ch.count),
    .cmd          (cmd),
    .status       (status),
    .result_key   (out_ch.result_key),
    .result_count (out_ch.result_count),
    .last         (out_ch.last),
    .empty_map    (out_ch.empty_map),
    .overflow     (out_ch.overflow)
  );

  `ASSERT_NEVER(a_no_accept_while_sending, clk, rst, in_ch.ready && out_ch.valid)
  `ASSERT_ALWAYS(a_empty_is_last, clk, rst, (out_ch.valid && out_ch.empty_map) |-> out_ch.last)
  `ASSERT_ALWAYS(a_overflow_sticky, clk, rst, out_ch.overflow |=> out_ch.overflow)
  `ASSERT_NEVER(a_single_mem_op, clk, rst, (cmd.insert || cmd.write_hit) && cmd.x_read)

endmodule

>>> hw/rtl/kcht_ctrl.sv
module kcht_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  kcht_pkg::cmd_t         in_cmd,
  input  logic                   in_is_null,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  kcht_pkg::ctrl_status_t status,
  output kcht_pkg::ctrl_cmd_t    cmd
);
  import kcht_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_EXTRACT) begin
            state_next = ST_XREAD;
          end else if (!in_is_null) begin
            state_next = ST_MATCH;
          end
        end
      end
      ST_MATCH: state_next = ST_READ;
      ST_READ: begin
        if (status.hit) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_XREAD: state_next = ST_XSEND;
      ST_XSEND: begin
        if (out_ready) begin
          if (status.x_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_XREAD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        cmd.x_start = in_valid && (in_cmd == CMD_EXTRACT);
      end
      ST_MATCH: cmd.do_match = 1'b1;
      ST_READ: begin
        cmd.read_hit = status.hit;
        cmd.insert   = !status.hit && !status.full;
        cmd.set_ovf  = !status.hit && status.full;
      end
      ST_WRITE: cmd.write_hit = 1'b1;
      ST_XREAD: cmd.x_read = 1'b1;
      ST_XSEND: begin
        out_valid  = 1'b1;
        cmd.x_next = out_ready && !status.x_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/kcht_datapath.sv
module kcht_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [kcht_pkg::FIELD_W-1:0]        in_key,
  input  logic signed [kcht_pkg::FIELD_W-1:0] in_count,
  input  kcht_pkg::ctrl_cmd_t                 cmd,
  output kcht_pkg::ctrl_status_t              status,
  output logic [kcht_pkg::FIELD_W-1:0]        result_key,
  output logic signed [kcht_pkg::FIELD_W-1:0] result_count,
  output logic                                last,
  output logic                                empty_map,
  output logic                                overflow
);
  import kcht_pkg::*;

  logic [KEY_WIDTH-1:0]        key_table [TABLE_DEPTH];
  logic signed [FIELD_W-1:0]   count_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]            used;
  logic                        overflow_seen;
  logic [KEY_WIDTH-1:0]        key_reg;
  logic signed [FIELD_W-1:0]   count_reg;
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            xidx;
  logic signed [FIELD_W-1:0]   rd_data;
  logic [KEY_WIDTH-1:0]        res_key;
  logic                        res_last;
  logic                        res_empty;

  logic [TABLE_DEPTH-1:0]      match_vec;
  logic [IDX_W-1:0]            match_enc;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic signed [FIELD_W-1:0]   mem_wdata;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;

  always_comb begin
    match_enc = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_vec[i] = (CNT_W'(i) < used) && (key_table[i] == key_reg);
      match_enc    = match_enc | (match_vec[i] ? IDX_W'(i) : '0);
    end
  end

  assign mem_we    = cmd.insert || cmd.write_hit;
  assign mem_waddr = cmd.insert ? used[IDX_W-1:0] : hit_idx;
  assign mem_wdata = cmd.insert ? count_reg : rd_data + count_reg;
  assign mem_re    = cmd.read_hit || cmd.x_read;
  assign mem_raddr = cmd.x_read ? xidx : hit_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= count_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.insert) begin
        used <= used + CNT_W'(1);
      end
      if (cmd.set_ovf) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_reg   <= in_key[KEY_WIDTH-1:0];
      count_reg <= in_count;
    end
    if (cmd.do_match) begin
      hit     <= |match_vec;
      hit_idx <= match_enc;
    end
    if (cmd.insert) begin
      key_table[used[IDX_W-1:0]] <= key_reg;
    end
    if (cmd.x_start) begin
      xidx <= '0;
    end else if (cmd.x_next) begin
      xidx <= xidx + IDX_W'(1);
    end
    if (cmd.x_read) begin
      res_key   <= key_table[xidx];
      res_last  <= (used == CNT_W'(xidx) + CNT_W'(1));
      res_empty <= (used == '0);
    end
  end

  assign status.hit    = hit;
  assign status.full   = (used == CNT_W'(TABLE_DEPTH));
  assign status.x_last = res_last || res_empty;

  assign result_key   = res_empty ? '0 : FIELD_W'(res_key);
  assign result_count = res_empty ? '0 : rd_data;
  assign last         = res_last || res_empty;
  assign empty_map    = res_empty;
  assign overflow     = overflow_seen;

endmodule
